// File: src/bfs_pkg.sv
// Shared constants, codes and control types for the biased factorization SGD block.
// Used by the interfaces, configuration, controller, datapath and top level.
package bfs_pkg;

    localparam int NUM_USERS   = 524288;
    localparam int NUM_MOVIES  = 32768;
    localparam int MAX_FACTORS = 128;

    localparam int FRAC_BITS = 24;
    localparam int USER_W    = 19;
    localparam int MOVIE_W   = 15;
    localparam int RATING_W  = 3;
    localparam int SLOT_W    = 8;
    localparam int VALUE_W   = 32;
    localparam int PRED_W    = 27;
    localparam int RESID_W   = 28;
    localparam int COEF_W    = 24;
    localparam int MEAN_W    = 27;
    localparam int AF_W      = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 27;

    localparam int UA_W   = $clog2(NUM_USERS);
    localparam int MA_W   = $clog2(NUM_MOVIES);
    localparam int FIDX_W = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;
    localparam int NF_W   = $clog2(MAX_FACTORS + 1);
    localparam int ACC_W  = 48;

    localparam logic [SLOT_W-1:0]   BIAS_SLOT  = 8'd128;
    localparam logic [RATING_W-1:0] RATING_MIN = 3'd1;
    localparam logic [RATING_W-1:0] RATING_MAX = 3'd5;
    localparam logic [PRED_W-1:0]   PRED_MIN_Q = 27'd16777216;
    localparam logic [PRED_W-1:0]   PRED_MAX_Q = 27'd83886080;

    typedef enum logic [1:0] {
        OP_TRAIN      = 2'd0,
        OP_PREDICT    = 2'd1,
        OP_LOAD_USER  = 2'd2,
        OP_LOAD_MOVIE = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FACTOR_RATE    = 3'd0,
        CFG_FACTOR_DECAY   = 3'd1,
        CFG_BIAS_RATE      = 3'd2,
        CFG_BIAS_DECAY     = 3'd3,
        CFG_MEAN_RATING    = 3'd4,
        CFG_ACTIVE_FACTORS = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [COEF_W-1:0] factor_rate;
        logic [COEF_W-1:0] factor_decay;
        logic [COEF_W-1:0] bias_rate;
        logic [COEF_W-1:0] bias_decay;
        logic [MEAN_W-1:0] mean_rating;
        logic [AF_W-1:0]   active_factors;
    } cfg_t;

    typedef enum logic [15:0] {
        ST_IDLE  = 16'h0001,
        ST_LOAD  = 16'h0002,
        ST_BRD   = 16'h0004,
        ST_BACC  = 16'h0008,
        ST_DRD   = 16'h0010,
        ST_DMUL  = 16'h0020,
        ST_DACC  = 16'h0040,
        ST_CLAMP = 16'h0080,
        ST_URD   = 16'h0100,
        ST_UMUL1 = 16'h0200,
        ST_UMUL2 = 16'h0400,
        ST_UWR   = 16'h0800,
        ST_BG    = 16'h1000,
        ST_BD    = 16'h2000,
        ST_BWR   = 16'h4000,
        ST_FIN   = 16'h8000
    } state_t;

    typedef struct packed {
        logic            latch;
        logic            load_wr;
        logic            bias_acc;
        logic            dot_mul;
        logic            dot_acc;
        logic            clamp;
        logic            upd_g;
        logic            upd_d;
        logic            upd_wr;
        logic            bias_g;
        logic            bias_d;
        logic            bias_wr;
        logic            result;
        logic [NF_W-1:0] k;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic out_free;
    } status_t;

endpackage

// File: src/bfs_in_if.sv
// Input channel: one training, predict or load item per beat.
// Depends on bfs_pkg for field widths.
interface bfs_in_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  operation;
    logic [bfs_pkg::USER_W-1:0]  user_index;
    logic [bfs_pkg::MOVIE_W-1:0] movie_index;
    logic [bfs_pkg::RATING_W-1:0] rating;
    logic [bfs_pkg::SLOT_W-1:0]  factor_slot;
    logic signed [bfs_pkg::VALUE_W-1:0] load_value;

    modport source (output valid, operation, user_index, movie_index, rating,
                    factor_slot, load_value, input ready);
    modport sink (input valid, operation, user_index, movie_index, rating,
                  factor_slot, load_value, output ready);
endinterface

// File: src/bfs_out_if.sv
// Result channel: one estimate and residual per beat.
// Depends on bfs_pkg for field widths.
interface bfs_out_if;
    logic                               valid;
    logic                               ready;
    logic [bfs_pkg::PRED_W-1:0]         prediction;
    logic signed [bfs_pkg::RESID_W-1:0] residual;

    modport source (output valid, prediction, residual, input ready);
    modport sink (input valid, prediction, residual, output ready);
endinterface

// File: src/bfs_cfg.sv
// Configuration registers written through the plain write port.
// Depends on bfs_pkg for the register codes and the cfg_t bundle.
module bfs_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [bfs_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [bfs_pkg::CFG_DATA_W-1:0]     wr_data,
    output bfs_pkg::cfg_t                      cfg
);

    bfs_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.factor_rate    <= 24'd83886;
            cfg_reg.factor_decay   <= 24'd201327;
            cfg_reg.bias_rate      <= 24'd16777;
            cfg_reg.bias_decay     <= 24'd16777;
            cfg_reg.mean_rating    <= 27'd60397978;
            cfg_reg.active_factors <= 8'd120;
        end
        else if (wr_en)
        begin
            case (wr_index)
                bfs_pkg::CFG_FACTOR_RATE:    cfg_reg.factor_rate  <= wr_data[23:0];
                bfs_pkg::CFG_FACTOR_DECAY:   cfg_reg.factor_decay <= wr_data[23:0];
                bfs_pkg::CFG_BIAS_RATE:      cfg_reg.bias_rate    <= wr_data[23:0];
                bfs_pkg::CFG_BIAS_DECAY:     cfg_reg.bias_decay   <= wr_data[23:0];
                bfs_pkg::CFG_MEAN_RATING:    cfg_reg.mean_rating  <= wr_data[26:0];
                bfs_pkg::CFG_ACTIVE_FACTORS: cfg_reg.active_factors <= wr_data[7:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/bfs_ctrl.sv
// Sequencer: per item walks a load, or the bias read, dot product, clamp and train-only update phases.
// Depends on bfs_pkg for the state encoding and command/status types.
module bfs_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [bfs_pkg::AF_W-1:0]     active_factors,
    input  bfs_pkg::status_t             status,
    output bfs_pkg::cmd_t                cmd
);

    bfs_pkg::state_t          state_reg, state_next;
    logic [bfs_pkg::NF_W-1:0] k_reg, k_next;
    logic [bfs_pkg::NF_W-1:0] nf;
    logic                     last_k;

    always_comb
    begin
        if (32'(active_factors) > bfs_pkg::MAX_FACTORS)
            nf = bfs_pkg::NF_W'(bfs_pkg::MAX_FACTORS);
        else
            nf = bfs_pkg::NF_W'(active_factors);
    end

    assign last_k   = (k_reg + 1'b1) == nf;
    assign in_ready = (state_reg == bfs_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        case (state_reg)
            bfs_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = bfs_pkg::ST_BRD;
            end
            bfs_pkg::ST_BRD:
            begin
                // The item is latched now, so loads branch off here.
                if (status.op == bfs_pkg::OP_LOAD_USER || status.op == bfs_pkg::OP_LOAD_MOVIE)
                    state_next = bfs_pkg::ST_LOAD;
                else
                    state_next = bfs_pkg::ST_BACC;
            end
            bfs_pkg::ST_LOAD:  state_next = bfs_pkg::ST_FIN;
            bfs_pkg::ST_BACC:
            begin
                k_next     = '0;
                state_next = (nf == '0) ? bfs_pkg::ST_CLAMP : bfs_pkg::ST_DRD;
            end
            bfs_pkg::ST_DRD:   state_next = bfs_pkg::ST_DMUL;
            bfs_pkg::ST_DMUL:  state_next = bfs_pkg::ST_DACC;
            bfs_pkg::ST_DACC:
            begin
                k_next     = k_reg + 1'b1;
                state_next = last_k ? bfs_pkg::ST_CLAMP : bfs_pkg::ST_DRD;
            end
            bfs_pkg::ST_CLAMP:
            begin
                k_next = '0;
                if (status.op != bfs_pkg::OP_TRAIN)
                    state_next = bfs_pkg::ST_FIN;
                else
                    state_next = (nf == '0) ? bfs_pkg::ST_BG : bfs_pkg::ST_URD;
            end
            bfs_pkg::ST_URD:   state_next = bfs_pkg::ST_UMUL1;
            bfs_pkg::ST_UMUL1: state_next = bfs_pkg::ST_UMUL2;
            bfs_pkg::ST_UMUL2: state_next = bfs_pkg::ST_UWR;
            bfs_pkg::ST_UWR:
            begin
                k_next     = k_reg + 1'b1;
                state_next = last_k ? bfs_pkg::ST_BG : bfs_pkg::ST_URD;
            end
            bfs_pkg::ST_BG:    state_next = bfs_pkg::ST_BD;
            bfs_pkg::ST_BD:    state_next = bfs_pkg::ST_BWR;
            bfs_pkg::ST_BWR:   state_next = bfs_pkg::ST_FIN;
            bfs_pkg::ST_FIN:
            begin
                if (status.out_free)
                    state_next = bfs_pkg::ST_IDLE;
            end
            default:           state_next = bfs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bfs_pkg::ST_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        cmd          = '0;
        cmd.k        = k_reg;
        cmd.latch    = (state_reg == bfs_pkg::ST_IDLE) && in_valid;
        cmd.load_wr  = (state_reg == bfs_pkg::ST_LOAD);
        cmd.bias_acc = (state_reg == bfs_pkg::ST_BACC);
        cmd.dot_mul  = (state_reg == bfs_pkg::ST_DMUL);
        cmd.dot_acc  = (state_reg == bfs_pkg::ST_DACC);
        cmd.clamp    = (state_reg == bfs_pkg::ST_CLAMP);
        cmd.upd_g    = (state_reg == bfs_pkg::ST_UMUL1);
        cmd.upd_d    = (state_reg == bfs_pkg::ST_UMUL2);
        cmd.upd_wr   = (state_reg == bfs_pkg::ST_UWR);
        cmd.bias_g   = (state_reg == bfs_pkg::ST_BG);
        cmd.bias_d   = (state_reg == bfs_pkg::ST_BD);
        cmd.bias_wr  = (state_reg == bfs_pkg::ST_BWR);
        cmd.result   = (state_reg == bfs_pkg::ST_FIN) && status.out_free;
    end

endmodule

// File: src/bfs_datapath.sv
// Stores, multipliers, accumulator and output register of the SGD step.
// Depends on bfs_pkg; driven by the command bundle from bfs_ctrl.
module bfs_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bfs_pkg::cmd_t                       cmd,
    output bfs_pkg::status_t                    status,
    input  bfs_pkg::cfg_t                       cfg,
    input  logic [1:0]                          operation,
    input  logic [bfs_pkg::USER_W-1:0]          user_index,
    input  logic [bfs_pkg::MOVIE_W-1:0]         movie_index,
    input  logic [bfs_pkg::RATING_W-1:0]        rating,
    input  logic [bfs_pkg::SLOT_W-1:0]          factor_slot,
    input  logic signed [bfs_pkg::VALUE_W-1:0]  load_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bfs_pkg::PRED_W-1:0]          prediction,
    output logic signed [bfs_pkg::RESID_W-1:0]  residual
);

    localparam int UF_DEPTH = bfs_pkg::NUM_USERS * bfs_pkg::MAX_FACTORS;
    localparam int MF_DEPTH = bfs_pkg::NUM_MOVIES * bfs_pkg::MAX_FACTORS;

    // Round a Q.48 product of two Q.24 values to Q.24: add half, floor shift.
    function automatic logic signed [63:0] rnd(input logic signed [63:0] x);
        return (x + 64'sd8388608) >>> bfs_pkg::FRAC_BITS;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (x < -64'sd2147483648)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

    logic [31:0] uf_mem [UF_DEPTH];
    logic [31:0] mf_mem [MF_DEPTH];
    logic [31:0] ub_mem [bfs_pkg::NUM_USERS];
    logic [31:0] mb_mem [bfs_pkg::NUM_MOVIES];

    bfs_pkg::op_t                     op_reg;
    logic [bfs_pkg::USER_W-1:0]       user_reg;
    logic [bfs_pkg::MOVIE_W-1:0]      movie_reg;
    logic [bfs_pkg::RATING_W-1:0]     rating_reg;
    logic [bfs_pkg::SLOT_W-1:0]       slot_reg;
    logic signed [31:0]               lv_reg;

    logic signed [31:0] uf_rd_reg, mf_rd_reg, ub_rd_reg, mb_rd_reg;
    logic signed [31:0] u_reg, v_reg, ub_reg, mb_reg;
    logic signed [bfs_pkg::ACC_W-1:0] acc_reg;
    logic signed [39:0] prod_reg;
    logic [bfs_pkg::PRED_W-1:0]       pred_reg;
    logic signed [bfs_pkg::RESID_W-1:0] err_reg;
    logic signed [36:0] gu_reg, gv_reg;
    logic signed [37:0] du_reg, dv_reg;
    logic signed [33:0] gbu_reg, gbm_reg;
    logic signed [34:0] dbu_reg, dbm_reg;

    logic                             out_valid_reg;
    logic [bfs_pkg::PRED_W-1:0]       out_pred_reg;
    logic signed [bfs_pkg::RESID_W-1:0] out_resid_reg;

    logic uok, mok, slot_fac, slot_bias;
    logic [bfs_pkg::FIDX_W-1:0] fidx, kidx;
    logic [bfs_pkg::UA_W+bfs_pkg::FIDX_W-1:0] uf_raddr, uf_waddr;
    logic [bfs_pkg::MA_W+bfs_pkg::FIDX_W-1:0] mf_raddr, mf_waddr;
    logic uf_we, mf_we, ub_we, mb_we;
    logic [31:0] uf_wdata, mf_wdata, ub_wdata, mb_wdata;
    logic signed [31:0] u_in, v_in;
    logic signed [63:0] err64, fd64, fr64, bd64, br64;
    logic [bfs_pkg::RATING_W-1:0] rating_sat;
    logic [bfs_pkg::PRED_W-1:0] pred_n;

    assign uok       = 32'(user_reg) < bfs_pkg::NUM_USERS;
    assign mok       = 32'(movie_reg) < bfs_pkg::NUM_MOVIES;
    assign slot_bias = (slot_reg == bfs_pkg::BIAS_SLOT);
    assign slot_fac  = 32'(slot_reg) < bfs_pkg::MAX_FACTORS;
    assign kidx      = cmd.k[bfs_pkg::FIDX_W-1:0];
    assign fidx      = cmd.load_wr ? slot_reg[bfs_pkg::FIDX_W-1:0] : kidx;

    assign uf_raddr = {user_reg[bfs_pkg::UA_W-1:0], kidx};
    assign mf_raddr = {movie_reg[bfs_pkg::MA_W-1:0], kidx};
    assign uf_waddr = {user_reg[bfs_pkg::UA_W-1:0], fidx};
    assign mf_waddr = {movie_reg[bfs_pkg::MA_W-1:0], fidx};

    assign u_in = uok ? uf_rd_reg : 32'sd0;
    assign v_in = mok ? mf_rd_reg : 32'sd0;

    assign err64 = 64'(err_reg);
    assign fd64  = 64'($signed({1'b0, cfg.factor_decay}));
    assign fr64  = 64'($signed({1'b0, cfg.factor_rate}));
    assign bd64  = 64'($signed({1'b0, cfg.bias_decay}));
    assign br64  = 64'($signed({1'b0, cfg.bias_rate}));

    always_comb
    begin
        uf_we = 1'b0;
        mf_we = 1'b0;
        ub_we = 1'b0;
        mb_we = 1'b0;
        uf_wdata = lv_reg;
        mf_wdata = lv_reg;
        ub_wdata = lv_reg;
        mb_wdata = lv_reg;
        if (cmd.load_wr)
        begin
            if (op_reg == bfs_pkg::OP_LOAD_USER && uok)
            begin
                uf_we = slot_fac;
                ub_we = slot_bias;
            end
            if (op_reg == bfs_pkg::OP_LOAD_MOVIE && mok)
            begin
                mf_we = slot_fac;
                mb_we = slot_bias;
            end
        end
        if (cmd.upd_wr)
        begin
            uf_we    = uok;
            mf_we    = mok;
            uf_wdata = sat32(64'(u_reg) + 64'(du_reg));
            mf_wdata = sat32(64'(v_reg) + 64'(dv_reg));
        end
        if (cmd.bias_wr)
        begin
            ub_we    = uok;
            mb_we    = mok;
            ub_wdata = sat32(64'(ub_reg) + 64'(dbu_reg));
            mb_wdata = sat32(64'(mb_reg) + 64'(dbm_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (uf_we)
            uf_mem[uf_waddr] <= uf_wdata;
        uf_rd_reg <= uf_mem[uf_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (mf_we)
            mf_mem[mf_waddr] <= mf_wdata;
        mf_rd_reg <= mf_mem[mf_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ub_we)
            ub_mem[user_reg[bfs_pkg::UA_W-1:0]] <= ub_wdata;
        ub_rd_reg <= ub_mem[user_reg[bfs_pkg::UA_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (mb_we)
            mb_mem[movie_reg[bfs_pkg::MA_W-1:0]] <= mb_wdata;
        mb_rd_reg <= mb_mem[movie_reg[bfs_pkg::MA_W-1:0]];
    end

    always_comb
    begin
        if (rating < bfs_pkg::RATING_MIN)
            rating_sat = bfs_pkg::RATING_MIN;
        else if (rating > bfs_pkg::RATING_MAX)
            rating_sat = bfs_pkg::RATING_MAX;
        else
            rating_sat = rating;

        if (acc_reg > $signed(bfs_pkg::ACC_W'(bfs_pkg::PRED_MAX_Q)))
            pred_n = bfs_pkg::PRED_MAX_Q;
        else if (acc_reg < $signed(bfs_pkg::ACC_W'(bfs_pkg::PRED_MIN_Q)))
            pred_n = bfs_pkg::PRED_MIN_Q;
        else
            pred_n = acc_reg[bfs_pkg::PRED_W-1:0];
    end

    // Item payload and arithmetic pipeline registers.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg     <= bfs_pkg::op_t'(operation);
            user_reg   <= user_index;
            movie_reg  <= movie_index;
            rating_reg <= rating_sat;
            slot_reg   <= factor_slot;
            lv_reg     <= load_value;
        end
        if (cmd.bias_acc)
        begin
            ub_reg  <= uok ? ub_rd_reg : 32'sd0;
            mb_reg  <= mok ? mb_rd_reg : 32'sd0;
            acc_reg <= $signed(bfs_pkg::ACC_W'(cfg.mean_rating))
                     + bfs_pkg::ACC_W'(uok ? ub_rd_reg : 32'sd0)
                     + bfs_pkg::ACC_W'(mok ? mb_rd_reg : 32'sd0);
        end
        if (cmd.dot_mul)
            prod_reg <= 40'(rnd(64'(u_in) * 64'(v_in)));
        if (cmd.dot_acc)
            acc_reg <= acc_reg + bfs_pkg::ACC_W'(prod_reg);
        if (cmd.clamp)
        begin
            pred_reg <= pred_n;
            err_reg  <= $signed({1'b0, rating_reg, 24'd0})
                      - $signed({1'b0, pred_n});
        end
        if (cmd.upd_g)
        begin
            u_reg  <= u_in;
            v_reg  <= v_in;
            gu_reg <= 37'(rnd(err64 * 64'(v_in)) - rnd(fd64 * 64'(u_in)));
            gv_reg <= 37'(rnd(err64 * 64'(u_in)) - rnd(fd64 * 64'(v_in)));
        end
        if (cmd.upd_d)
        begin
            du_reg <= 38'(rnd(fr64 * 64'(gu_reg)));
            dv_reg <= 38'(rnd(fr64 * 64'(gv_reg)));
        end
        if (cmd.bias_g)
        begin
            gbu_reg <= 34'(err64 - rnd(bd64 * 64'(ub_reg)));
            gbm_reg <= 34'(err64 - rnd(bd64 * 64'(mb_reg)));
        end
        if (cmd.bias_d)
        begin
            dbu_reg <= 35'(rnd(br64 * 64'(gbu_reg)));
            dbm_reg <= 35'(rnd(br64 * 64'(gbm_reg)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.result)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result)
        begin
            if (op_reg == bfs_pkg::OP_LOAD_USER || op_reg == bfs_pkg::OP_LOAD_MOVIE)
                out_pred_reg <= '0;
            else
                out_pred_reg <= pred_reg;
            out_resid_reg <= (op_reg == bfs_pkg::OP_TRAIN) ? err_reg : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign prediction = out_pred_reg;
    assign residual   = out_resid_reg;

    assign status.op       = op_reg;
    assign status.out_free = !out_valid_reg || out_ready;

endmodule

// File: src/biased_factorization_sgd_step.sv
// Biased matrix factorization SGD step: one item at a time, Q8.24 arithmetic.
// Load: BRD, LOAD, FIN. Predict: BRD, BACC, then a store read, multiply and accumulate
// per factor (N = active factors, capped at 128), CLAMP, FIN.
// Train adds URD, UMUL1, UMUL2, UWR per factor and BG, BD, BWR. FIN waits for a free
// output; the next item can be taken as the result appears. Reset clears configuration to
// defaults, the sequencer and the result beat; the factor and bias stores are not cleared.
module biased_factorization_sgd_step (
    input  logic                           clk,
    input  logic                           rst_n,
    bfs_in_if.sink                         req,
    bfs_out_if.source                      rsp,
    input  logic                           wr_en,
    input  logic [bfs_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [bfs_pkg::CFG_DATA_W-1:0] wr_data
);

    bfs_pkg::cfg_t    cfg;
    bfs_pkg::cmd_t    cmd;
    bfs_pkg::status_t status;
    logic             in_ready;

    bfs_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    bfs_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (req.valid),
        .in_ready       (in_ready),
        .active_factors (cfg.active_factors),
        .status         (status),
        .cmd            (cmd)
    );

    bfs_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg         (cfg),
        .operation   (req.operation),
        .user_index  (req.user_index),
        .movie_index (req.movie_index),
        .rating      (req.rating),
        .factor_slot (req.factor_slot),
        .load_value  (req.load_value),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .prediction  (rsp.prediction),
        .residual    (rsp.residual)
    );

    assign req.ready = in_ready;

`ifndef SYNTHESIS
    // A result beat is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result |-> (!rsp.valid || rsp.ready))
        else $error("result loaded while output beat pending");

    // Once an item is taken the block stops accepting until it is finished.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("second item accepted during processing");

    // Factor walks never index past MAX_FACTORS.
    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.dot_acc || cmd.upd_wr) |-> (32'(cmd.k) < bfs_pkg::MAX_FACTORS))
        else $error("factor index out of range");
`endif

endmodule

// File: tb/sv/bfs_tb_pkg.sv
// Testbench-side types for the biased factorization SGD step checker.
// Depends on bfs_pkg for field widths and operation codes.
package bfs_tb_pkg;
    import bfs_pkg::*;

    typedef struct {
        op_t                       op;
        logic [USER_W-1:0]         user;
        logic [MOVIE_W-1:0]        movie;
        logic [RATING_W-1:0]       rating;
        logic [SLOT_W-1:0]         slot;
        logic signed [VALUE_W-1:0] value;
    } rating_item_t;

    typedef struct {
        logic [PRED_W-1:0]         prediction;
        logic signed [RESID_W-1:0] residual;
    } estimate_t;
endpackage

// File: tb/sv/tb_channels.sv
// Testbench copies of the item and result channels are not needed; the RTL
// interfaces bfs_in_if and bfs_out_if are used directly. This file holds the
// watchdog limit used by the top module; it depends on no other package.
package tb_limits_pkg;
    localparam int STALL_LIMIT = 20000;
endpackage

// File: tb/sv/tb_top.sv
// Self-checking bench for biased_factorization_sgd_step: loads vectors and biases,
// trains and predicts, and compares each result beat with a Q8.24 predictor.
// Depends on bfs_pkg, bfs_tb_pkg, tb_limits_pkg and the two channel interfaces.
module tb_top;
    import bfs_pkg::*;
    import bfs_tb_pkg::*;
    import tb_limits_pkg::*;

    localparam int NU = 3;   // users and movies touched by the stimulus
    localparam int NM = 3;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    bfs_in_if req ();
    bfs_out_if rsp ();

    biased_factorization_sgd_step dut (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
    );

    // Shadow copy of the stores for the few entries the stimulus uses.
    longint user_fac[NU][MAX_FACTORS];
    longint movie_fac[NM][MAX_FACTORS];
    longint user_bias[NU];
    longint movie_bias[NM];
    logic [USER_W-1:0] user_ids[NU];
    logic [MOVIE_W-1:0] movie_ids[NM];

    longint f_rate, f_decay, b_rate, b_decay, mean_q, n_active;

    rating_item_t pending_items[$];
    estimate_t expected_estimates[$];
    int errors;
    int accepted_in;
    int results_seen;
    int idle_cycles;
    bit hold_sender;
    bit stimulus_done;
    int in_gap;
    int out_gap;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic longint fl_shift24(longint x);
        return x >>> FRAC_BITS;
    endfunction

    function automatic longint q_round(longint x);
        return fl_shift24(x + (longint'(1) << (FRAC_BITS - 1)));
    endfunction

    function automatic longint sat_word(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic int user_slot(logic [USER_W-1:0] id);
        for (int i = 0; i < NU; i++)
            if (user_ids[i] == id)
                return i;
        return -1;
    endfunction

    function automatic int movie_slot(logic [MOVIE_W-1:0] id);
        for (int i = 0; i < NM; i++)
            if (movie_ids[i] == id)
                return i;
        return -1;
    endfunction

    // Works out the estimate and applies the SGD step to the shadow stores.
    function automatic estimate_t sgd_estimate(rating_item_t it);
        estimate_t r;
        int ui;
        int mi;
        longint nf;
        longint acc;
        longint err;
        longint rt;
        longint u;
        longint v;
        longint gu;
        longint gv;
        longint ub;
        longint mb;
        ui = user_slot(it.user);
        mi = movie_slot(it.movie);
        r.prediction = '0;
        r.residual = '0;
        if (it.op == OP_LOAD_USER || it.op == OP_LOAD_MOVIE)
        begin
            if (it.op == OP_LOAD_USER && ui >= 0)
            begin
                if (it.slot == BIAS_SLOT)
                    user_bias[ui] = longint'(it.value);
                else if (it.slot < MAX_FACTORS)
                    user_fac[ui][it.slot] = longint'(it.value);
            end
            if (it.op == OP_LOAD_MOVIE && mi >= 0)
            begin
                if (it.slot == BIAS_SLOT)
                    movie_bias[mi] = longint'(it.value);
                else if (it.slot < MAX_FACTORS)
                    movie_fac[mi][it.slot] = longint'(it.value);
            end
            return r;
        end
        nf = (n_active > MAX_FACTORS) ? MAX_FACTORS : n_active;
        ub = user_bias[ui];
        mb = movie_bias[mi];
        acc = mean_q + ub + mb;
        for (int k = 0; k < nf; k++)
            acc += q_round(user_fac[ui][k] * movie_fac[mi][k]);
        if (acc > (longint'(5) << FRAC_BITS))
            acc = longint'(5) << FRAC_BITS;
        if (acc < (longint'(1) << FRAC_BITS))
            acc = longint'(1) << FRAC_BITS;
        r.prediction = acc[PRED_W-1:0];
        if (it.op == OP_TRAIN)
        begin
            rt = longint'(it.rating);
            if (rt < 1)
                rt = 1;
            if (rt > 5)
                rt = 5;
            err = (rt << FRAC_BITS) - acc;
            r.residual = err[RESID_W-1:0];
            for (int k = 0; k < nf; k++)
            begin
                u = user_fac[ui][k];
                v = movie_fac[mi][k];
                gu = q_round(err * v) - q_round(f_decay * u);
                gv = q_round(err * u) - q_round(f_decay * v);
                user_fac[ui][k] = sat_word(u + q_round(f_rate * gu));
                movie_fac[mi][k] = sat_word(v + q_round(f_rate * gv));
            end
            user_bias[ui] = sat_word(ub + q_round(b_rate * (err - q_round(b_decay * ub))));
            movie_bias[mi] = sat_word(mb + q_round(b_rate * (err - q_round(b_decay * mb))));
        end
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch in %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    // Driver: presents queued items, idling at random between beats.
    always @(posedge clk or negedge rst_n)
    begin
        rating_item_t it;
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            in_gap <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                accepted_in <= accepted_in + 1;
                expected_estimates.push_back(sgd_estimate(pending_items.pop_front()));
            end
            if (req.valid && !req.ready)
                ;
            else if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                req.valid <= 1'b0;
            end
            else if (pending_items.size() > 0 && !hold_sender)
            begin
                // The beat just taken is already off the queue, so the front is next.
                it = pending_items[0];
                req.valid <= 1'b1;
                req.operation <= it.op;
                req.user_index <= it.user;
                req.movie_index <= it.movie;
                req.rating <= it.rating;
                req.factor_slot <= it.slot;
                req.load_value <= it.value;
                in_gap <= gap_len();
            end
            else
                req.valid <= 1'b0;
        end
    end

    // Monitor: stalls the result channel at random and checks each beat.
    always @(posedge clk or negedge rst_n)
    begin
        estimate_t e;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            out_gap <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_estimates.size() == 0)
                    report_mismatch("result count", results_seen + 1, accepted_in);
                else
                begin
                    e = expected_estimates.pop_front();
                    if (rsp.prediction !== e.prediction)
                        report_mismatch("prediction", rsp.prediction, e.prediction);
                    if (rsp.residual !== e.residual)
                        report_mismatch("residual", rsp.residual, e.residual);
                end
            end
            if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= 1'b1;
                if (rsp.valid && rsp.ready)
                    out_gap <= gap_len();
            end
        end
    end

    // Watchdog on cycles in which no beat moves on either channel and no configuration write occurs.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_n || wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic push_item(op_t op, logic [USER_W-1:0] user, logic [MOVIE_W-1:0] movie,
                             logic [RATING_W-1:0] rating, logic [SLOT_W-1:0] slot,
                             logic signed [VALUE_W-1:0] value);
        rating_item_t it;
        it.op = op;
        it.user = user;
        it.movie = movie;
        it.rating = rating;
        it.slot = slot;
        it.value = value;
        pending_items.push_back(it);
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || expected_estimates.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, longint value);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            CFG_FACTOR_RATE:    f_rate = value & 24'hFFFFFF;
            CFG_FACTOR_DECAY:   f_decay = value & 24'hFFFFFF;
            CFG_BIAS_RATE:      b_rate = value & 24'hFFFFFF;
            CFG_BIAS_DECAY:     b_decay = value & 24'hFFFFFF;
            CFG_MEAN_RATING:    mean_q = value & 27'h7FFFFFF;
            CFG_ACTIVE_FACTORS: n_active = value & 8'hFF;
            default: ;
        endcase
    endtask

    // Random small values keep training stable; a few large ones reach saturation.
    function automatic logic signed [VALUE_W-1:0] rand_value();
        if ($urandom_range(0, 19) == 0)
            return $urandom();
        return $signed($urandom_range(0, 1 << 23)) - (1 << 22);
    endfunction

    // Fill every factor and bias of one user and one movie so no undefined read occurs.
    task automatic load_pair(int ui, int mi);
        for (int k = 0; k < MAX_FACTORS; k++)
        begin
            push_item(OP_LOAD_USER, user_ids[ui], 0, 0, k[SLOT_W-1:0], rand_value());
            push_item(OP_LOAD_MOVIE, 0, movie_ids[mi], 0, k[SLOT_W-1:0], rand_value());
        end
        push_item(OP_LOAD_USER, user_ids[ui], 0, 0, BIAS_SLOT, rand_value());
        push_item(OP_LOAD_MOVIE, 0, movie_ids[mi], 0, BIAS_SLOT, rand_value());
    endtask

    task automatic random_use(int count);
        int p;
        for (int n = 0; n < count; n++)
        begin
            p = $urandom_range(0, 9);
            if (p < 6)
                push_item(OP_TRAIN, user_ids[$urandom_range(0, NU-1)],
                          movie_ids[$urandom_range(0, NM-1)], $urandom_range(0, 7),
                          $urandom(), $urandom());
            else if (p < 8)
                push_item(OP_PREDICT, user_ids[$urandom_range(0, NU-1)],
                          movie_ids[$urandom_range(0, NM-1)], $urandom_range(0, 7),
                          $urandom(), $urandom());
            else if (p == 8)
                push_item(OP_LOAD_USER, user_ids[$urandom_range(0, NU-1)], $urandom(), 0,
                          ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 128),
                          rand_value());
            else
                push_item(OP_LOAD_MOVIE, $urandom(), movie_ids[$urandom_range(0, NM-1)], 0,
                          ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 128),
                          rand_value());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        req.valid = 1'b0;
        req.operation = '0;
        req.user_index = '0;
        req.movie_index = '0;
        req.rating = '0;
        req.factor_slot = '0;
        req.load_value = '0;
        rsp.ready = 1'b0;
        errors = 0;
        accepted_in = 0;
        results_seen = 0;
        idle_cycles = 0;
        hold_sender = 0;
        f_rate = 83886;
        f_decay = 201327;
        b_rate = 16777;
        b_decay = 16777;
        mean_q = 60397978;
        n_active = 120;
        // Extreme indexes sit among the tracked ones so every field bit toggles.
        user_ids[0] = '0;
        user_ids[1] = USER_W'(NUM_USERS - 1);
        movie_ids[0] = '0;
        movie_ids[1] = MOVIE_W'(NUM_MOVIES - 1);
        for (int i = 2; i < NU; i++)
            user_ids[i] = USER_W'($urandom_range(1, NUM_USERS - 2) ^ (i << 10));
        for (int i = 2; i < NM; i++)
            movie_ids[i] = MOVIE_W'($urandom_range(1, NUM_MOVIES - 2) ^ (i << 8));
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Small vectors first so the directed part stays short and cheap.
        write_reg(CFG_ACTIVE_FACTORS, 4);
        for (int i = 0; i < NU; i++)
            load_pair(i, i);
        push_item(OP_LOAD_USER, user_ids[0], 0, 0, BIAS_SLOT, 32'sh7FFFFFFF);
        push_item(OP_LOAD_MOVIE, 0, movie_ids[0], 0, BIAS_SLOT, 32'sh7FFFFFFF);
        push_item(OP_TRAIN, user_ids[0], movie_ids[0], 3'd0, 0, 0);   // rating zero, top clamp
        push_item(OP_TRAIN, user_ids[0], movie_ids[0], 3'd7, 0, 0);   // rating above five
        push_item(OP_LOAD_USER, user_ids[1], 0, 0, BIAS_SLOT, 32'sh80000000);
        push_item(OP_TRAIN, user_ids[1], movie_ids[1], 3'd5, 0, 0);   // bottom clamp
        push_item(OP_PREDICT, user_ids[1], movie_ids[1], 3'd1, 0, 0);
        push_item(OP_LOAD_USER, user_ids[2], 0, 0, 8'd200, -1);       // ignored slot
        push_item(OP_LOAD_MOVIE, 0, movie_ids[2], 0, 8'd255, -1);
        drain();
        write_reg(CFG_ACTIVE_FACTORS, 0);                              // no factors in use
        push_item(OP_TRAIN, user_ids[2], movie_ids[2], 3'd4, 0, 0);
        drain();
        write_reg(CFG_ACTIVE_FACTORS, 255);                            // saturates to max
        write_reg(CFG_FACTOR_RATE, 24'hFFFFFF);
        write_reg(CFG_FACTOR_DECAY, 0);
        write_reg(CFG_BIAS_RATE, 24'hFFFFFF);
        write_reg(CFG_BIAS_DECAY, 24'hFFFFFF);
        write_reg(CFG_MEAN_RATING, 100663296);
        push_item(OP_TRAIN, user_ids[2], movie_ids[2], 3'd1, 0, 0);
        push_item(OP_PREDICT, user_ids[2], movie_ids[2], 3'd2, 0, 0);
        drain();

        write_reg(CFG_MEAN_RATING, 0);
        write_reg(CFG_FACTOR_RATE, 0);
        write_reg(CFG_FACTOR_DECAY, 24'hFFFFFF);
        write_reg(CFG_BIAS_RATE, 0);
        write_reg(CFG_BIAS_DECAY, 0);
        write_reg(CFG_ACTIVE_FACTORS, 1);
        random_use(60);
        drain();

        for (int phase = 0; phase < 5; phase++)
        begin
            write_reg(CFG_FACTOR_RATE, $urandom_range(0, 1 << 21));
            write_reg(CFG_FACTOR_DECAY, $urandom_range(0, 1 << 22));
            write_reg(CFG_BIAS_RATE, $urandom_range(0, 1 << 21));
            write_reg(CFG_BIAS_DECAY, $urandom_range(0, 1 << 22));
            write_reg(CFG_MEAN_RATING, $urandom_range(0, 100663296));
            write_reg(CFG_ACTIVE_FACTORS, (phase == 4) ? 128 : $urandom_range(1, 16));
            random_use(phase == 4 ? 40 : 65);
            if (phase == 2)
            begin
                // Sender holds off until the pipeline is empty.
                while (pending_items.size() > 30)
                    @(posedge clk);
                hold_sender = 1;
                while (expected_estimates.size() > 0 || req.valid)
                    @(posedge clk);
                hold_sender = 0;
            end
            drain();
        end

        repeat (50) @(posedge clk);
        $display("Covered %0d items and %0d results over loads, train and predict,",
                 accepted_in, results_seen);
        $display("with configuration extremes and random rates and factor counts.");
        if (errors == 0 && expected_estimates.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
